// ===== rtl/mme_pkg.sv =====
// Shared constants for the modular exponentiation block.
package mme_pkg;

	// Default operand width; products stay within 2*WIDTH bits.
	localparam int MME_WIDTH = 32;

	// Port width of every operand and result field.
	localparam int MME_PORT_W = 32;

endpackage

// ===== rtl/mme_mulmod.sv =====
// Shared bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle.
module mme_mulmod import mme_pkg::*; #(
	parameter int WIDTH = MME_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] result
);

	localparam int CW = $clog2(WIDTH + 1);

	logic             run_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r_q;

	logic [WIDTH+1:0] t;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH+1:0] d1;
	logic [WIDTH+1:0] d2;
	logic [WIDTH-1:0] r_nxt;

	// r < m and a <= m keep t below 3m: at most two subtractions of m.
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[WIDTH-1] ? a_q : {WIDTH{1'b0}})};
		m1 = {2'b00, m_q};
		m2 = {1'b0, m_q, 1'b0};
		d1 = t - m1;
		d2 = t - m2;
		if (t >= m2) begin
			r_nxt = d2[WIDTH-1:0];
		end else if (t >= m1) begin
			r_nxt = d1[WIDTH-1:0];
		end else begin
			r_nxt = t[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= r_nxt;
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level: right-to-left binary modular exponentiation over a shared modular multiplier.
//
//  channel   | handshake                 | fields
//  ----------+---------------------------+----------------------------
//  item in   | start & !busy             | base, exponent, modulus
//  result    | done (one-cycle strobe)   | power_mod
//
// An item with a zero exponent or zero modulus is answered straight from idle,
// without the multiplier. Otherwise the base is first reduced mod modulus,
// then each exponent bit below the top set bit costs a squaring plus, on set
// bits, a multiply, and the top set bit costs only the multiply; each step is
// one pass through the shared multiplier. Reset clears the sequencer only.
// busy is high for the whole of an item that uses the multiplier; the result
// strobe cannot be held off by the receiver.
module modular_exponentiation import mme_pkg::*; #(
	parameter int WIDTH = MME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [MME_PORT_W-1:0] base,
	input  logic [MME_PORT_W-1:0] exponent,
	input  logic [MME_PORT_W-1:0] modulus,
	output logic                  done,
	output logic [MME_PORT_W-1:0] power_mod
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,    // base mod modulus
		S_CHECK,  // pick next operation from the low exponent bit
		S_MUL,    // acc = acc * base mod modulus
		S_SQR     // base = base * base mod modulus
	} state_t;

	state_t                state_q;
	logic                  done_q;
	logic [MME_PORT_W-1:0] power_mod_q;
	logic [WIDTH-1:0]      exp_q;
	logic [WIDTH-1:0]      base_q;
	logic [WIDTH-1:0]      acc_q;
	logic [WIDTH-1:0]      mod_q;

	// Launch of the shared multiplier; operands are registered with the pulse.
	logic                  mm_go_q;
	logic [WIDTH-1:0]      op_a_q;
	logic [WIDTH-1:0]      op_b_q;
	logic                  mm_done;
	logic [WIDTH-1:0]      mm_result;

	logic                  accept;
	logic [WIDTH-1:0]      base_in;
	logic [WIDTH-1:0]      exp_in;
	logic [WIDTH-1:0]      mod_in;

	// Bits above WIDTH are ignored.
	assign base_in = base[WIDTH-1:0];
	assign exp_in  = exponent[WIDTH-1:0];
	assign mod_in  = modulus[WIDTH-1:0];
	assign accept  = start && !busy;

	mme_mulmod #(
		.WIDTH (WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mm_go_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.m      (mod_q),
		.done   (mm_done),
		.result (mm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			mm_go_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			mm_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						exp_q <= exp_in;
						mod_q <= mod_in;
						acc_q <= WIDTH'(1);
						if (exp_in == '0) begin
							// zero exponent: 1, unreduced, even for modulus 1
							power_mod_q <= MME_PORT_W'(1);
							done_q      <= 1'b1;
						end else if (mod_in == '0) begin
							power_mod_q <= '0;
							done_q      <= 1'b1;
						end else begin
							// 1 * base mod m reduces the raw base
							op_a_q  <= WIDTH'(1);
							op_b_q  <= base_in;
							mm_go_q <= 1'b1;
							state_q <= S_PRE;
						end
					end
				end
				S_PRE: begin
					if (mm_done) begin
						base_q  <= mm_result;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					op_a_q  <= base_q;
					mm_go_q <= 1'b1;
					if (exp_q[0]) begin
						op_b_q  <= acc_q;
						state_q <= S_MUL;
					end else begin
						op_b_q  <= base_q;
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (mm_done) begin
						acc_q <= mm_result;
						if (exp_q[WIDTH-1:1] == '0) begin
							// top bit done; the last squaring is not needed
							power_mod_q <= MME_PORT_W'(mm_result);
							done_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							op_a_q  <= base_q;
							op_b_q  <= base_q;
							mm_go_q <= 1'b1;
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_done) begin
						base_q  <= mm_result;
						exp_q   <= exp_q >> 1;
						state_q <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign power_mod = power_mod_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module tb_top import mme_pkg::*; ();

	localparam int OPW = MME_WIDTH;
	localparam int DIRECTED_ITEMS = 18;
	localparam int RANDOM_ITEMS = 262;
	localparam int QUIET_TAIL = 40;     // last items go out back to back
	localparam int STRETCH = 25;        // idle and non-idle stretches alternate
	localparam int DRAIN_GAP = 100;     // cycles watched for stray strobes at the end
	// The timeout allows several times the slowest run.
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [MME_PORT_W-1:0] base;
		logic [MME_PORT_W-1:0] exponent;
		logic [MME_PORT_W-1:0] modulus;
		int unsigned           gap;     // free cycles to leave before this item
		bit                    drain;   // hold until every result is back
	} exp_job_t;

	typedef struct {
		logic [MME_PORT_W-1:0] base;
		logic [MME_PORT_W-1:0] exponent;
		logic [MME_PORT_W-1:0] modulus;
		logic [MME_PORT_W-1:0] power_mod;
	} pow_due_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [MME_PORT_W-1:0] base = '0;
	logic [MME_PORT_W-1:0] exponent = '0;
	logic [MME_PORT_W-1:0] modulus = '0;
	logic                  done;
	logic [MME_PORT_W-1:0] power_mod;

	exp_job_t    jobs[$];       // items not yet offered
	pow_due_t    pows_due[$];   // results owed by the block, oldest first
	exp_job_t    cur;           // item currently on the input ports
	pow_due_t    got;
	bit          offering = 1'b0;
	bit          gap_set = 1'b0;
	int unsigned gap_left = 0;
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned zero_exp_items = 0;
	int unsigned full_exp_items = 0;
	longint      cycles = 0;

	modular_exponentiation #(.WIDTH(OPW)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.base     (base),
		.exponent (exponent),
		.modulus  (modulus),
		.done     (done),
		.power_mod(power_mod)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is held low at the start, then released away from the active edge.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Right-to-left square and multiply on 64-bit words. Operands are cut to
	// the operand width first so every product fits. Zero exponent gives 1
	// even for modulus 1; zero modulus gives 0 otherwise.
	function automatic logic [MME_PORT_W-1:0] power_mod_of(logic [MME_PORT_W-1:0] b_in,
			logic [MME_PORT_W-1:0] e_in, logic [MME_PORT_W-1:0] m_in);
		logic [63:0] op_mask;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] m;
		logic [63:0] acc;
		op_mask = (64'd1 << OPW) - 64'd1;
		b = {32'd0, b_in} & op_mask;
		e = {32'd0, e_in} & op_mask;
		m = {32'd0, m_in} & op_mask;
		acc = 64'd1;
		if (e == 64'd0)
			return MME_PORT_W'(1);
		if (m == 64'd0)
			return '0;
		while (e != 64'd0) begin
			if (e[0])
				acc = (b * acc) % m;
			e = e >> 1;
			b = (b * b) % m;
		end
		return acc[MME_PORT_W-1:0];
	endfunction

	task automatic queue_job(logic [MME_PORT_W-1:0] b, logic [MME_PORT_W-1:0] e,
			logic [MME_PORT_W-1:0] m, int unsigned gap, bit drain);
		exp_job_t j;
		j.base = b;
		j.exponent = e;
		j.modulus = m;
		j.gap = gap;
		j.drain = drain;
		jobs.insert(jobs.size(), j);
	endtask

	// Driver: inputs move on the falling edge. An offered item stays put
	// until the monitor sees start & !busy; idle gaps only count down on
	// cycles where the block is free, so they land between items.
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (!gap_set && jobs.size() > 0) begin
				gap_left = jobs[0].gap;
				gap_set = 1'b1;
			end
			if (gap_set && gap_left == 0 && !(jobs[0].drain && pows_due.size() > 0)) begin
				cur = jobs.pop_front();
				gap_set = 1'b0;
				offering = 1'b1;
				start <= 1'b1;
				base <= cur.base;
				exponent <= cur.exponent;
				modulus <= cur.modulus;
			end else begin
				if (gap_left > 0 && !busy)
					gap_left--;
				// junk on the operand ports while start is low must be ignored
				start <= 1'b0;
				base <= $urandom;
				exponent <= $urandom;
				modulus <= $urandom;
			end
		end
	end

	// Monitor: samples on the rising edge. A strobe is checked before a new
	// acceptance is recorded, since it always belongs to an older item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pows_due.size() == 0) begin
					errors++;
					$display("%0t: result strobe with nothing owed, power_mod %h",
						$time, power_mod);
				end else begin
					got = pows_due.pop_front();
					checked++;
					if (power_mod !== got.power_mod) begin
						errors++;
						$display("%0t: power_mod for %h^%h mod %h: expected %h, actual %h",
							$time, got.base, got.exponent, got.modulus,
							got.power_mod, power_mod);
					end
				end
			end
			if (start && !busy) begin
				got.base = cur.base;
				got.exponent = cur.exponent;
				got.modulus = cur.modulus;
				got.power_mod = power_mod_of(cur.base, cur.exponent, cur.modulus);
				pows_due.insert(pows_due.size(), got);
				offering = 1'b0;
				if (cur.exponent == '0)
					zero_exp_items++;
				if (cur.exponent[MME_PORT_W-1])
					full_exp_items++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still owed", $time, pows_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [MME_PORT_W-1:0] b;
		logic [MME_PORT_W-1:0] e;
		logic [MME_PORT_W-1:0] m;
		int unsigned len;
		int unsigned gap;
		bit idle_ok;

		// Directed: field extremes, the zero exponent (also with modulus 1),
		// base at or past the modulus, single-bit and all-ones exponents.
		queue_job(32'd2, 32'd10, 32'd1000, 0, 1'b0);
		queue_job(32'd5, 32'd0, 32'd1, 0, 1'b0);
		queue_job(32'd0, 32'd0, 32'hFFFF_FFFF, 2, 1'b0);
		queue_job(32'd0, 32'd5, 32'd7, 0, 1'b0);
		queue_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		queue_job(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 1, 1'b0);
		queue_job(32'd12345, 32'd1, 32'd100, 0, 1'b0);
		queue_job(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd1, 0, 1'b0);
		queue_job(32'd3, 32'd7, 32'd2, 0, 1'b0);
		queue_job(32'd97, 32'd3, 32'd97, 0, 1'b1);
		queue_job(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF, 0, 1'b0);
		// Fermat: p = 2^32 - 5 is prime, so 3^(p-1) mod p is 1
		queue_job(32'd3, 32'hFFFF_FFFA, 32'hFFFF_FFFB, 3, 1'b0);
		queue_job(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 0, 1'b0);
		queue_job(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		queue_job(32'd7, 32'h8000_0000, 32'd1000003, 0, 1'b0);
		queue_job(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 1'b0);
		queue_job(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 0, 1'b0);
		queue_job(32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// modulus: mostly full range, some tiny, a few of exactly 1
			case ($urandom_range(0, 9))
				0:       m = 32'd1;
				1, 2, 3: m = $urandom_range(2, 300);
				default: m = $urandom;
			endcase
			if (m == '0)
				m = 32'd1;
			// base: random, small, hugging the modulus, or an extreme
			case ($urandom_range(0, 7))
				0:       b = $urandom_range(0, 15);
				1:       b = m - 32'd1;
				2:       b = m + $urandom_range(0, 1);
				3:       b = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
				default: b = $urandom;
			endcase
			// exponent: random significant length with the top bit set
			len = $urandom_range(0, 32);
			if (len == 0) begin
				e = '0;
			end else begin
				e = $urandom;
				if (len < 32)
					e = e & ((32'd1 << len) - 32'd1);
				e[len-1] = 1'b1;
			end
			idle_ok = ((i / STRETCH) % 2 == 0) && (i < RANDOM_ITEMS - QUIET_TAIL);
			gap = (idle_ok && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
			queue_job(b, e, m, gap, i == 0 || i == RANDOM_ITEMS / 2);
		end

		do
			@(posedge clk);
		while (jobs.size() > 0 || offering || pows_due.size() > 0);
		// watch a while longer for strobes nothing asked for
		repeat (DRAIN_GAP) @(posedge clk);

		$display("Checked %0d results: directed extremes plus random operands,", checked);
		$display("%0d items with a zero exponent and %0d with a full-width exponent",
			zero_exp_items, full_exp_items);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
